// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check prop on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that cond never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- hw/rtl/krpm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyed record prefix matcher package
// Widths, key codes, key text table and the result word type.
// ---------------------------------------------------------------------------
package krpm_pkg;

    localparam int OFF_W       = 13;
    localparam int POS_W       = 4;
    localparam int IDX_W       = 3;
    localparam int KEY_COUNT   = 6;
    localparam int KEY_MAX_LEN = 10;
    localparam int TEXT_W      = 8 * KEY_MAX_LEN;

    localparam logic [OFF_W-1:0]     MSG_BYTES = OFF_W'(4096);
    localparam logic [POS_W-1:0]     POS_LIMIT = POS_W'(15);
    localparam logic [KEY_COUNT-1:0] ALL_KEYS  = '1;

    localparam logic [IDX_W-1:0] KEY_ACTION    = 3'd0;
    localparam logic [IDX_W-1:0] KEY_DEVPATH   = 3'd1;
    localparam logic [IDX_W-1:0] KEY_SUBSYSTEM = 3'd2;
    localparam logic [IDX_W-1:0] KEY_DEVNAME   = 3'd3;
    localparam logic [IDX_W-1:0] KEY_DEVTYPE   = 3'd4;
    localparam logic [IDX_W-1:0] KEY_SEQNUM    = 3'd5;

    typedef struct packed {
        logic             key_found;
        logic [IDX_W-1:0] key_index;
        logic [OFF_W-1:0] value_offset;
        logic             message_done;
    } t_match_result;

    // Key text, left-justified: the first character sits in the top byte.
    function automatic logic [TEXT_W-1:0] key_text(input logic [IDX_W-1:0] k);
        logic [TEXT_W-1:0] s;
        case (k)
            KEY_ACTION:    s = {"ACTION=", 24'h0};
            KEY_DEVPATH:   s = {"DEVPATH=", 16'h0};
            KEY_SUBSYSTEM: s = "SUBSYSTEM=";
            KEY_DEVNAME:   s = {"DEVNAME=", 16'h0};
            KEY_DEVTYPE:   s = {"DEVTYPE=", 16'h0};
            KEY_SEQNUM:    s = {"SEQNUM=", 24'h0};
            default:       s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] key_char(input logic [IDX_W-1:0] k,
                                            input logic [POS_W-1:0] p);
        logic [TEXT_W-1:0] t;
        t = key_text(k) << {p, 3'b000};
        return t[TEXT_W-1 -: 8];
    endfunction

    function automatic logic [POS_W-1:0] key_len(input logic [IDX_W-1:0] k);
        logic [POS_W-1:0] n;
        case (k)
            KEY_ACTION:    n = POS_W'(7);
            KEY_DEVPATH:   n = POS_W'(8);
            KEY_SUBSYSTEM: n = POS_W'(10);
            KEY_DEVNAME:   n = POS_W'(8);
            KEY_DEVTYPE:   n = POS_W'(8);
            KEY_SEQNUM:    n = POS_W'(7);
            default:       n = '0;
        endcase
        return n;
    endfunction

endpackage

// ----- hw/rtl/krpm_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyed record prefix matcher stream interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface krpm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface krpm_out_if;
    import krpm_pkg::*;
    logic             valid;
    logic             ready;
    logic             key_found;
    logic [IDX_W-1:0] key_index;
    logic [OFF_W-1:0] value_offset;
    logic             message_done;

    modport source (output valid, output key_found, output key_index,
                    output value_offset, output message_done, input ready);
    modport sink   (input valid, input key_found, input key_index,
                    input value_offset, input message_done, output ready);
endinterface

// ----- hw/rtl/krpm_match.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyed record prefix matcher: match stage
// Input register, per-key prefix compare and the offset/position/mask state.
// ---------------------------------------------------------------------------
module krpm_match
    import krpm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    krpm_in_if.sink       i_in,
    input  logic          i_room,
    output logic          o_push,
    output t_match_result o_result
);

    logic                 r_in_valid;
    logic [7:0]           r_byte;
    logic                 r_eom;
    logic [OFF_W-1:0]     r_byte_offset;
    logic [POS_W-1:0]     r_pos;
    logic [KEY_COUNT-1:0] r_alive;

    logic [OFF_W-1:0]     n_byte_offset;
    logic [POS_W-1:0]     n_pos;
    logic [KEY_COUNT-1:0] n_alive;

    logic                 w_take;
    logic                 w_advance;
    logic                 w_found;
    logic [IDX_W-1:0]     w_idx;
    logic [OFF_W-1:0]     w_off_inc;
    logic                 w_hit;
    logic [POS_W-1:0]     w_len;

    assign i_in.ready = !r_in_valid || i_room;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_advance  = r_in_valid && i_room;

    assign w_off_inc = (r_byte_offset >= MSG_BYTES) ? MSG_BYTES : r_byte_offset + 1'b1;

    always_comb begin
        w_found = 1'b0;
        w_idx   = '0;
        w_hit   = 1'b0;
        w_len   = '0;
        n_alive = '0;
        n_pos   = r_pos;
        if (r_byte == 8'h00) begin
            n_pos   = '0;
            n_alive = ALL_KEYS;
        end else begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                w_len = key_len(IDX_W'(k));
                w_hit = r_alive[k] && (r_pos < w_len)
                        && (key_char(IDX_W'(k), r_pos) == r_byte);
                if (w_hit) begin
                    if (({1'b0, r_pos} + 5'd1) == {1'b0, w_len}) begin
                        w_found = 1'b1;
                        w_idx   = IDX_W'(k);
                    end else begin
                        n_alive[k] = 1'b1;
                    end
                end
            end
            n_pos = (r_pos >= POS_LIMIT) ? POS_LIMIT : r_pos + 1'b1;
        end
        n_byte_offset = w_off_inc;
        // end of message abandons the current record and rewinds the offset
        if (r_eom) begin
            n_byte_offset = '0;
            n_pos         = '0;
            n_alive       = ALL_KEYS;
        end
    end

    always_comb begin
        o_result.key_found    = w_found;
        o_result.key_index    = w_found ? w_idx : '0;
        o_result.value_offset = w_found ? w_off_inc : '0;
        o_result.message_done = r_eom;
    end

    assign o_push = w_advance && (w_found || r_eom);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_byte_offset <= '0;
            r_pos         <= '0;
            r_alive       <= ALL_KEYS;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_byte_offset <= n_byte_offset;
                r_pos         <= n_pos;
                r_alive       <= n_alive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_in.data_byte;
            r_eom  <= i_in.end_of_message;
        end
    end

endmodule

// ----- hw/rtl/krpm_out_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyed record prefix matcher: output queue
// Two-entry result queue; decouples output stalls from the match stage.
// ---------------------------------------------------------------------------
module krpm_out_fifo
    import krpm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_match_result i_data,
    output logic          o_room,
    krpm_out_if.source    o_out
);

    t_match_result r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    t_match_result w_head;
    logic          w_pop;

    assign w_head = r_mem[r_rd_ptr];
    assign w_pop  = o_out.valid && o_out.ready;
    assign o_room = (r_count != 2'd2);

    assign o_out.valid        = (r_count != 2'd0);
    assign o_out.key_found    = w_head.key_found;
    assign o_out.key_index    = w_head.key_index;
    assign o_out.value_offset = w_head.value_offset;
    assign o_out.message_done = w_head.message_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/keyed_record_prefix_matcher_top.sv -----
`timescale 1ns / 1ps
// Path: a byte that completes a key or ends a message is registered in the
//   match stage, then its result word is written into the output queue.
// Throughput: one byte per cycle while the output queue has room; the
//   two-entry output queue keeps input ready while one result waits.
// Reset: synchronous, active low; offset and position clear, all keys alive.
// ---------------------------------------------------------------------------
// Keyed record prefix matcher
// Scans NUL-separated records for six key prefixes and reports value offsets and end of message.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_record_prefix_matcher_top
    import krpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    krpm_in_if.sink    i_in,
    krpm_out_if.source o_out
);

    logic          w_push;
    logic          w_room;
    t_match_result w_result;

    krpm_match u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_room   (w_room),
        .o_push   (w_push),
        .o_result (w_result)
    );

    krpm_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_room  (w_room),
        .o_out   (o_out)
    );

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, w_push && !w_room, "push into full queue")
    `ASSERT_PROP(a_push_cause, i_clk, i_rst_n, w_push |-> (w_result.key_found || w_result.message_done), "empty result pushed")
    `ASSERT_PROP(a_index_range, i_clk, i_rst_n, (o_out.valid && o_out.key_found) |-> (o_out.key_index <= KEY_SEQNUM), "key index out of range")
    `ASSERT_PROP(a_no_key_zero, i_clk, i_rst_n, (o_out.valid && !o_out.key_found) |-> (o_out.key_index == '0 && o_out.value_offset == '0), "stray key fields")
    `ASSERT_PROP(a_offset_sat, i_clk, i_rst_n, o_out.valid |-> (o_out.value_offset <= MSG_BYTES), "offset beyond message size")

endmodule
